/* rtl/seglcd_pkg.sv */
// Shared types, constants and glyph helpers for the segment LCD number writer.
package seglcd_pkg;

	localparam int NUM_DIGITS_DEF = 6;
	localparam int IMAGE_BYTES    = 14;
	localparam int SLOT_W         = 4;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(IMAGE_BYTES - 1);

	localparam logic [1:0] CMD_WRITE_INT   = 2'd0;
	localparam logic [1:0] CMD_WRITE_DIGIT = 2'd1;
	localparam logic [1:0] CMD_SEG_ON      = 2'd2;
	localparam logic [1:0] CMD_SEG_OFF     = 2'd3;

	localparam logic [3:0] SEG_IND1  = 4'd1;
	localparam logic [3:0] SEG_IND2  = 4'd2;
	localparam logic [3:0] SEG_IND3  = 4'd3;
	localparam logic [3:0] SEG_IND4  = 4'd4;
	localparam logic [3:0] SEG_IND5  = 4'd5;
	localparam logic [3:0] SEG_IND7  = 4'd7;
	localparam logic [3:0] SEG_IND8  = 4'd8;
	localparam logic [3:0] SEG_IND9  = 4'd9;
	localparam logic [3:0] SEG_IND10 = 4'd10;

	localparam logic [7:0] KEEP_MASK  = 8'h66;
	localparam logic [3:0] MAX_DIGIT  = 4'd9;
	localparam logic [2:0] MAX_POS    = 3'd5;

	// ceil(2^23 / 10), exact quotient for any 20-bit value
	localparam logic [19:0] DIV10_RECIP = 20'd838861;
	localparam int          DIV10_SHIFT = 23;

	localparam logic [15:0] GLYPH [10] = '{
		16'h1551, 16'h8110, 16'h11e1, 16'h11b1, 16'h05b0,
		16'h14b1, 16'h14f1, 16'h1110, 16'h15f1, 16'h15b1
	};

	localparam logic [4:0] SLOT_REG [IMAGE_BYTES] = '{
		5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7,
		5'd10, 5'd11, 5'd12, 5'd15, 5'd16, 5'd17, 5'd18
	};

	typedef struct packed {
		logic [1:0]  command;
		logic [19:0] value;
		logic [3:0]  digit;
		logic [2:0]  position;
		logic [3:0]  segment_number;
	} in_item_t;

	typedef struct packed {
		logic [4:0] register_index;
		logic [7:0] register_value;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [SLOT_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_READ,
		ST_MODIFY
	} state_t;

	function automatic logic [3:0] glyph_nib(input logic [3:0] d, input logic [1:0] k);
		logic [15:0] g;
		g = (d <= MAX_DIGIT) ? GLYPH[d] : 16'h0000;
		unique case (k)
			2'd0: glyph_nib = g[15:12];
			2'd1: glyph_nib = g[11:8];
			2'd2: glyph_nib = g[7:4];
			default: glyph_nib = g[3:0];
		endcase
	endfunction

endpackage

/* rtl/segment_lcd_number_writer.sv */
// Segment LCD number writer: command sequencer, image read-modify-write and readout.
// Sequence: write integer first splits the value into digits; then each of the 14 image bytes is read
// and rewritten through the one-port image memory (read state, then modify state), one byte out each.
// A new request is taken only in idle, after the last byte is out; an output stall holds the modify state.
// Reset: image reads as all zero through per-byte valid flags; no clearing pass needed.
module segment_lcd_number_writer import seglcd_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	state_t                     state_q;
	state_t                     state_nxt;
	in_item_t                   item_q;
	logic [SLOT_W-1:0]          slot_q;
	logic                       res_valid_q;
	out_item_t                  res_q;
	logic                       accept;
	logic                       out_free;
	logic                       emit;
	logic                       split_done;
	logic [NUM_DIGITS-1:0][3:0] digits;
	logic [NUM_DIGITS-1:0]      digit_used;
	logic [7:0]                 rd_data;
	logic [7:0]                 new_byte;
	mem_req_t                   mem_req;

	assign accept   = req_valid && req_ready;
	assign out_free = !res_valid_q || res_ready;

	seglcd_digit_split #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && (req.command == CMD_WRITE_INT)),
		.value      (req.value),
		.done       (split_done),
		.digits     (digits),
		.digit_used (digit_used)
	);

	seglcd_image_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	seglcd_byte_update #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_update (
		.slot       (slot_q),
		.old_byte   (rd_data),
		.item       (item_q),
		.digits     (digits),
		.digit_used (digit_used),
		.new_byte   (new_byte)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = (req.command == CMD_WRITE_INT) ? ST_SPLIT : ST_READ;
				end
			end
			ST_SPLIT: begin
				if (split_done) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: state_nxt = ST_MODIFY;
			ST_MODIFY: begin
				if (out_free) begin
					state_nxt = (slot_q == LAST_SLOT) ? ST_IDLE : ST_READ;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		emit          = (state_q == ST_MODIFY) && out_free;
		mem_req.rd_en = (state_q == ST_READ);
		mem_req.wr_en = emit;
		mem_req.addr  = slot_q;
		mem_req.wdata = new_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				slot_q <= '0;
			end else if (emit) begin
				slot_q <= slot_q + 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (emit) begin
			res_q.register_index <= SLOT_REG[slot_q];
			res_q.register_value <= new_byte;
			res_q.last           <= (slot_q == LAST_SLOT);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/seglcd_image_ram.sv */
// Display image memory, registered synchronous read, zero until written.
module seglcd_image_ram import seglcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   mem_req,
	output logic [7:0] rd_data
);

	logic [7:0]             mem [IMAGE_BYTES];
	logic [IMAGE_BYTES-1:0] valid_q;
	logic [7:0]             rd_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem[mem_req.addr] <= mem_req.wdata;
		end
		if (mem_req.rd_en) begin
			rd_q <= mem[mem_req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mem_req.wr_en) begin
				valid_q[mem_req.addr] <= 1'b1;
			end
			if (mem_req.rd_en) begin
				rd_valid_q <= valid_q[mem_req.addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : 8'h00;

endmodule

/* rtl/seglcd_digit_split.sv */
// Iterative decimal digit extraction: each digit takes a reciprocal multiply step, then a remainder step.
module seglcd_digit_split import seglcd_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [19:0]                 value,
	output logic                        done,
	output logic [NUM_DIGITS-1:0][3:0]  digits,
	output logic [NUM_DIGITS-1:0]       digit_used
);

	localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);

	logic                       busy_q;
	logic                       phase_q;
	logic                       done_q;
	logic [IDX_W-1:0]           idx_q;
	logic [19:0]                cur_q;
	logic [39:0]                prod_q;
	logic [NUM_DIGITS-1:0][3:0] digits_q;
	logic [NUM_DIGITS-1:0]      used_q;
	logic [16:0]                quo;
	logic [20:0]                quo_x10;
	logic [20:0]                rem_full;

	assign quo      = prod_q[DIV10_SHIFT+16:DIV10_SHIFT];
	assign quo_x10  = {1'b0, quo, 3'b000} + {3'b000, quo, 1'b0};
	assign rem_full = {1'b0, cur_q} - quo_x10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				idx_q   <= '0;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (idx_q == LAST_IDX) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= value;
		end else if (busy_q) begin
			if (!phase_q) begin
				prod_q <= 40'(cur_q) * 40'(DIV10_RECIP);
			end else begin
				digits_q[idx_q] <= rem_full[3:0];
				// a leading zero past the units place is not a digit
				used_q[idx_q]   <= (idx_q == '0) || (cur_q != '0);
				cur_q           <= 20'(quo);
			end
		end
	end

	assign done       = done_q;
	assign digits     = digits_q;
	assign digit_used = used_q;

endmodule

/* rtl/seglcd_byte_update.sv */
// New content of one image byte for the current command.
module seglcd_byte_update import seglcd_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  logic [SLOT_W-1:0]           slot,
	input  logic [7:0]                  old_byte,
	input  in_item_t                    item,
	input  logic [NUM_DIGITS-1:0][3:0]  digits,
	input  logic [NUM_DIGITS-1:0]       digit_used,
	output logic [7:0]                  new_byte
);

	logic       is_dig;
	logic [1:0] row;
	logic [1:0] k;
	logic [2:0] lo_i;
	logic [2:0] hi_i;
	logic       lo_wr;
	logic       hi_wr;
	logic [3:0] lo_nib;
	logic [3:0] hi_nib;
	logic [7:0] base;
	logic [7:0] seg_bit;
	logic [SLOT_W-1:0] seg_slot;
	logic       seg_whole;
	logic       seg_hit;

	always_comb begin
		is_dig = 1'b1;
		row    = 2'd0;
		k      = 2'd0;
		priority if (slot < 4'd3) begin
			row = slot[1:0];
		end else if (slot == 4'd3) begin
			is_dig = 1'b0;
		end else if (slot < 4'd7) begin
			row = 2'(slot - 4'd4);
			k   = 2'd1;
		end else if (slot < 4'd10) begin
			row = 2'(slot - 4'd7);
			k   = 2'd2;
		end else if (slot < 4'd13) begin
			row = 2'(slot - 4'd10);
			k   = 2'd3;
		end else begin
			is_dig = 1'b0;
		end
	end

	assign lo_i = MAX_POS - {row, 1'b0};
	assign hi_i = 3'd4 - {row, 1'b0};

	always_comb begin
		lo_wr  = 1'b0;
		hi_wr  = 1'b0;
		lo_nib = 4'h0;
		hi_nib = 4'h0;
		for (int j = 0; j < NUM_DIGITS; j++) begin
			if (digit_used[j] && (3'(j) == lo_i)) begin
				lo_wr  = 1'b1;
				lo_nib = glyph_nib(digits[j], k);
			end
			if (digit_used[j] && (3'(j) == hi_i)) begin
				hi_wr  = 1'b1;
				hi_nib = glyph_nib(digits[j], k);
			end
		end
	end

	always_comb begin
		seg_bit   = 8'h00;
		seg_slot  = 4'd0;
		seg_whole = 1'b0;
		seg_hit   = 1'b1;
		unique case (item.segment_number)
			SEG_IND1:  seg_bit = 8'h04;
			SEG_IND2:  seg_bit = 8'h40;
			SEG_IND4: begin
				seg_slot = 4'd1;
				seg_bit  = 8'h02;
			end
			SEG_IND5: begin
				seg_slot = 4'd1;
				seg_bit  = 8'h20;
			end
			SEG_IND9: begin
				seg_slot = 4'd2;
				seg_bit  = 8'h04;
			end
			SEG_IND10: begin
				seg_slot = 4'd2;
				seg_bit  = 8'h40;
			end
			SEG_IND3: begin
				seg_slot  = 4'd3;
				seg_whole = 1'b1;
			end
			SEG_IND7, SEG_IND8: begin
				seg_slot  = LAST_SLOT;
				seg_whole = 1'b1;
			end
			default: seg_hit = 1'b0;
		endcase
	end

	always_comb begin
		new_byte = old_byte;
		base     = old_byte;
		unique case (item.command)
			CMD_WRITE_INT: begin
				if (slot < 4'd3) begin
					base = old_byte & KEEP_MASK;
				end else if (is_dig) begin
					base = 8'h00;
				end
				new_byte = base;
				if (is_dig && lo_wr) begin
					new_byte[3:0] = lo_nib;
				end
				if (is_dig && hi_wr) begin
					new_byte[7:4] = hi_nib;
				end
			end
			CMD_WRITE_DIGIT: begin
				if (is_dig && (item.position <= MAX_POS) && (item.digit <= MAX_DIGIT)
						&& (row == item.position[2:1])) begin
					if (item.position[0]) begin
						new_byte[7:4] = glyph_nib(item.digit, k);
					end else begin
						new_byte[3:0] = glyph_nib(item.digit, k);
					end
				end
			end
			default: begin
				if (seg_hit && (slot == seg_slot)) begin
					if (seg_whole) begin
						new_byte = (item.command == CMD_SEG_ON) ? 8'h01 : 8'h00;
					end else if (item.command == CMD_SEG_ON) begin
						new_byte = old_byte | seg_bit;
					end else begin
						new_byte = old_byte & ~seg_bit;
					end
				end
			end
		endcase
	end

endmodule
